/* hw/rtl/rvm_pkg.sv */
// ----------------------------------------------------------------------------
// rvm_pkg
// Constants, tables and types shared by the rotation vector to matrix block.
// ----------------------------------------------------------------------------
package rvm_pkg;

  // Pipeline section depths.
  localparam int SQRT_STAGES  = 32;
  localparam int CORDIC_STEPS = 30;
  localparam int DIV_STAGES   = 31;

  // Angle constants in Q.30.
  localparam logic [32:0] HALF_PI_Q30  = 33'd1686629713;
  localparam logic [32:0] TWO_HP_Q30   = 33'd3373259426;
  localparam logic [32:0] THREE_HP_Q30 = 33'd5059889139;
  localparam logic [32:0] FOUR_HP_Q30  = 33'd6746518852;

  // CORDIC start value (inverse gain) in Q.30.
  localparam logic signed [33:0] CORDIC_START_Q30 = 34'sd652032874;

  // Clamp limit for sine and cosine, 1.0 in Q.30.
  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

  // Number of matrix entries.
  localparam int NUM_M = 9;

  // Per item context that rides along the front of the pipeline.
  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic               zero;
  } ctx_t;

  // Truncated arctangent table, atan(2^-i) in Q.30.
  function automatic logic [32:0] atan_q30(input int i);
    logic [32:0] v;
    case (i)
      0:       v = 33'h03243F6A8;
      1:       v = 33'h01DAC6705;
      2:       v = 33'h00FADBAFC;
      3:       v = 33'h007F56EA6;
      4:       v = 33'h003FEAB76;
      5:       v = 33'h001FFD55B;
      6:       v = 33'h000FFFAAA;
      7:       v = 33'h0007FFF55;
      8:       v = 33'h0003FFFEA;
      9:       v = 33'h0001FFFFD;
      10:      v = 33'h0000FFFFF;
      11:      v = 33'h00007FFFF;
      12:      v = 33'h00003FFFF;
      13:      v = 33'h00001FFFF;
      14:      v = 33'h00000FFFF;
      15:      v = 33'h000007FFF;
      16:      v = 33'h000003FFF;
      17:      v = 33'h000001FFF;
      18:      v = 33'h000000FFF;
      19:      v = 33'h0000007FF;
      20:      v = 33'h0000003FF;
      21:      v = 33'h0000001FF;
      22:      v = 33'h0000000FF;
      23:      v = 33'h00000007F;
      24:      v = 33'h00000003F;
      25:      v = 33'h00000001F;
      26:      v = 33'h00000000F;
      27:      v = 33'h000000008;
      28:      v = 33'h000000004;
      29:      v = 33'h000000002;
      default: v = 33'h000000000;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/rotation_vector_to_matrix.sv */
// ----------------------------------------------------------------------------
// rotation_vector_to_matrix
// Pipelined rotation vector to 3x3 rotation matrix through a half angle
// quaternion: square root, CORDIC, three dividers and a product stage.
// ----------------------------------------------------------------------------
// Depth: 104 register stages from an input transaction to the output
// transaction of its result.
// Throughput: one transaction per cycle; the depth is set by the 32 stage
// square root, the 30 stage CORDIC and the 31 stage restoring dividers.
// A stall at the output holds the whole pipeline in place.
// Reset (synchronous, active low) clears all stage valid bits.
module rotation_vector_to_matrix #(
  parameter int IN_WIDTH  = 16,
  parameter int OUT_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [IN_WIDTH-1:0]  in_rot_x,
  input  logic signed [IN_WIDTH-1:0]  in_rot_y,
  input  logic signed [IN_WIDTH-1:0]  in_rot_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [OUT_WIDTH-1:0] out_m00,
  output logic signed [OUT_WIDTH-1:0] out_m01,
  output logic signed [OUT_WIDTH-1:0] out_m02,
  output logic signed [OUT_WIDTH-1:0] out_m10,
  output logic signed [OUT_WIDTH-1:0] out_m11,
  output logic signed [OUT_WIDTH-1:0] out_m12,
  output logic signed [OUT_WIDTH-1:0] out_m20,
  output logic signed [OUT_WIDTH-1:0] out_m21,
  output logic signed [OUT_WIDTH-1:0] out_m22,
  output logic                        out_zero_vector
);
  import rvm_pkg::*;

  localparam int LAT = 2 + SQRT_STAGES + 2 + CORDIC_STEPS + 3 + DIV_STAGES + 4;
  localparam int SCL = 32 - IN_WIDTH;
  localparam int SH  = 62 - OUT_WIDTH;
  localparam logic signed [63:0] RND = 64'sd1 <<< (SH - 1);
  localparam logic signed [63:0] LIM = 64'sd1 <<< (OUT_WIDTH - 2);

  logic adv;
  logic [LAT-1:0] vld_r;

  // The pipeline moves whenever the output register is free or being taken.
  assign adv       = !vld_r[LAT-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // Stage 1: scale to Q4.28 and square each component.
  logic signed [31:0] sx, sy, sz;
  logic signed [63:0] px, py, pz;
  ctx_t               s1_ctx_r;
  logic [63:0]        s1_sqx_r, s1_sqy_r, s1_sqz_r;

  assign sx = 32'(in_rot_x) <<< SCL;
  assign sy = 32'(in_rot_y) <<< SCL;
  assign sz = 32'(in_rot_z) <<< SCL;
  assign px = sx * sx;
  assign py = sy * sy;
  assign pz = sz * sz;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctx_r <= '{rx: sx, ry: sy, rz: sz, zero: 1'b0};
      s1_sqx_r <= px;
      s1_sqy_r <= py;
      s1_sqz_r <= pz;
    end
  end

  // Stage 2: sum of squares and zero vector detect; seeds the square root.
  logic [63:0] sq_a_r   [SQRT_STAGES+1];
  logic [31:0] sq_res_r [SQRT_STAGES+1];
  logic [35:0] sq_rem_r [SQRT_STAGES+1];
  ctx_t        sq_ctx_r [SQRT_STAGES+1];
  logic [63:0] sum_sq;

  assign sum_sq = s1_sqx_r + s1_sqy_r + s1_sqz_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_a_r[0]   <= sum_sq;
      sq_res_r[0] <= '0;
      sq_rem_r[0] <= '0;
      sq_ctx_r[0] <= '{rx: s1_ctx_r.rx, ry: s1_ctx_r.ry, rz: s1_ctx_r.rz,
                       zero: (sum_sq == 64'd0)};
    end
  end

  // Square root: one result bit per stage, restoring.
  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
    logic [35:0] cur, trial;
    logic        ge;
    assign cur   = {sq_rem_r[g][33:0], sq_a_r[g][63:62]};
    assign trial = {2'b00, sq_res_r[g], 2'b01};
    assign ge    = (cur >= trial);
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_a_r[g+1]   <= sq_a_r[g] << 2;
        sq_res_r[g+1] <= {sq_res_r[g][30:0], ge};
        sq_rem_r[g+1] <= ge ? (cur - trial) : cur;
        sq_ctx_r[g+1] <= sq_ctx_r[g];
      end
    end
  end

  // Range reduction, part one: drop a full turn of the half angle.
  logic [32:0] h2;
  logic [32:0] rd1_h_r;
  logic [31:0] rd1_n_r;
  ctx_t        rd1_ctx_r;

  assign h2 = {sq_res_r[SQRT_STAGES], 1'b0};

  always_ff @(posedge clk) begin
    if (adv) begin
      rd1_h_r   <= (h2 >= FOUR_HP_Q30) ? (h2 - FOUR_HP_Q30) : h2;
      rd1_n_r   <= sq_res_r[SQRT_STAGES];
      rd1_ctx_r <= sq_ctx_r[SQRT_STAGES];
    end
  end

  // Range reduction, part two: quadrant and remainder; seeds the CORDIC.
  logic signed [33:0] cx_r [CORDIC_STEPS+1];
  logic signed [33:0] cy_r [CORDIC_STEPS+1];
  logic signed [32:0] cz_r [CORDIC_STEPS+1];
  logic [1:0]         cq_r [CORDIC_STEPS+1];
  logic [31:0]        cn_r [CORDIC_STEPS+1];
  ctx_t               cc_r [CORDIC_STEPS+1];
  logic [1:0]         quad;
  logic [32:0]        trem;

  always_comb begin
    if (rd1_h_r >= THREE_HP_Q30) begin
      quad = 2'd3;
      trem = rd1_h_r - THREE_HP_Q30;
    end else if (rd1_h_r >= TWO_HP_Q30) begin
      quad = 2'd2;
      trem = rd1_h_r - TWO_HP_Q30;
    end else if (rd1_h_r >= HALF_PI_Q30) begin
      quad = 2'd1;
      trem = rd1_h_r - HALF_PI_Q30;
    end else begin
      quad = 2'd0;
      trem = rd1_h_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx_r[0] <= CORDIC_START_Q30;
      cy_r[0] <= '0;
      cz_r[0] <= signed'(trem);
      cq_r[0] <= quad;
      cn_r[0] <= rd1_n_r;
      cc_r[0] <= rd1_ctx_r;
    end
  end

  // CORDIC rotation, one micro-rotation per stage.
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    logic signed [33:0] xs, ys;
    logic signed [32:0] at;
    logic               pos;
    assign xs  = cx_r[g] >>> g;
    assign ys  = cy_r[g] >>> g;
    assign at  = signed'(atan_q30(g));
    assign pos = !cz_r[g][32];
    always_ff @(posedge clk) begin
      if (adv) begin
        cx_r[g+1] <= pos ? (cx_r[g] - ys) : (cx_r[g] + ys);
        cy_r[g+1] <= pos ? (cy_r[g] + xs) : (cy_r[g] - xs);
        cz_r[g+1] <= pos ? (cz_r[g] - at) : (cz_r[g] + at);
        cq_r[g+1] <= cq_r[g];
        cn_r[g+1] <= cn_r[g];
        cc_r[g+1] <= cc_r[g];
      end
    end
  end

  // Quadrant mapping and clamp to the unit range.
  logic signed [33:0] cm, sm;
  logic signed [31:0] mp_c_r, mp_s_r;
  logic [31:0]        mp_n_r;
  ctx_t               mp_ctx_r;

  always_comb begin
    case (cq_r[CORDIC_STEPS])
      2'd0: begin
        cm = cx_r[CORDIC_STEPS];
        sm = cy_r[CORDIC_STEPS];
      end
      2'd1: begin
        cm = -cy_r[CORDIC_STEPS];
        sm = cx_r[CORDIC_STEPS];
      end
      2'd2: begin
        cm = -cx_r[CORDIC_STEPS];
        sm = -cy_r[CORDIC_STEPS];
      end
      default: begin
        cm = cy_r[CORDIC_STEPS];
        sm = -cx_r[CORDIC_STEPS];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mp_c_r   <= (cm > ONE_Q30) ? 32'(ONE_Q30) : (cm < -ONE_Q30) ? 32'(-ONE_Q30) : 32'(cm);
      mp_s_r   <= (sm > ONE_Q30) ? 32'(ONE_Q30) : (sm < -ONE_Q30) ? 32'(-ONE_Q30) : 32'(sm);
      mp_n_r   <= cn_r[CORDIC_STEPS];
      mp_ctx_r <= cc_r[CORDIC_STEPS];
    end
  end

  // Numerators of the vector part: s times each component.
  logic signed [63:0] ml_p_r [3];
  logic signed [31:0] ml_w_r;
  logic [31:0]        ml_n_r;
  logic               ml_zero_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ml_p_r[0] <= mp_s_r * mp_ctx_r.rx;
      ml_p_r[1] <= mp_s_r * mp_ctx_r.ry;
      ml_p_r[2] <= mp_s_r * mp_ctx_r.rz;
      ml_w_r    <= mp_c_r;
      ml_n_r    <= mp_n_r;
      ml_zero_r <= mp_ctx_r.zero;
    end
  end

  // Divider setup: magnitude plus half the divisor, sign kept aside.
  logic [63:0]        dv_rem_r [DIV_STAGES+1][3];
  logic [30:0]        dv_q_r   [DIV_STAGES+1][3];
  logic [2:0]         dv_neg_r [DIV_STAGES+1];
  logic signed [31:0] dv_w_r   [DIV_STAGES+1];
  logic [31:0]        dv_n_r   [DIV_STAGES+1];
  logic               dv_zero_r[DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        dv_rem_r[0][k] <= (ml_p_r[k][63] ? 64'(-ml_p_r[k]) : 64'(ml_p_r[k]))
                          + 64'(ml_n_r >> 1);
        dv_q_r[0][k]   <= '0;
        dv_neg_r[0][k] <= ml_p_r[k][63];
      end
      dv_w_r[0]    <= ml_w_r;
      dv_n_r[0]    <= ml_n_r;
      dv_zero_r[0] <= ml_zero_r;
    end
  end

  // Restoring division by the norm, one quotient bit per stage.
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    localparam int B = DIV_STAGES - 1 - g;
    logic [63:0] trial;
    assign trial = 64'(dv_n_r[g]) << B;
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int k = 0; k < 3; k++) begin
          if (dv_rem_r[g][k] >= trial) begin
            dv_rem_r[g+1][k] <= dv_rem_r[g][k] - trial;
            dv_q_r[g+1][k]   <= dv_q_r[g][k] | (31'd1 << B);
          end else begin
            dv_rem_r[g+1][k] <= dv_rem_r[g][k];
            dv_q_r[g+1][k]   <= dv_q_r[g][k];
          end
        end
        dv_neg_r[g+1]  <= dv_neg_r[g];
        dv_w_r[g+1]    <= dv_w_r[g];
        dv_n_r[g+1]    <= dv_n_r[g];
        dv_zero_r[g+1] <= dv_zero_r[g];
      end
    end
  end

  // Restore signs of the quaternion vector part.
  logic signed [31:0] qt_r [4];
  logic               qt_zero_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      qt_r[0] <= dv_w_r[DIV_STAGES];
      for (int k = 0; k < 3; k++) begin
        qt_r[k+1] <= dv_neg_r[DIV_STAGES][k] ? -32'(dv_q_r[DIV_STAGES][k])
                                             : 32'(dv_q_r[DIV_STAGES][k]);
      end
      qt_zero_r <= dv_zero_r[DIV_STAGES];
    end
  end

  // Quaternion products in Q.60.
  logic signed [63:0] ww_r, xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  logic               pr_zero_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ww_r      <= qt_r[0] * qt_r[0];
      xx_r      <= qt_r[1] * qt_r[1];
      yy_r      <= qt_r[2] * qt_r[2];
      zz_r      <= qt_r[3] * qt_r[3];
      xy_r      <= qt_r[1] * qt_r[2];
      xz_r      <= qt_r[1] * qt_r[3];
      yz_r      <= qt_r[2] * qt_r[3];
      wx_r      <= qt_r[0] * qt_r[1];
      wy_r      <= qt_r[0] * qt_r[2];
      wz_r      <= qt_r[0] * qt_r[3];
      pr_zero_r <= qt_zero_r;
    end
  end

  // Matrix entries in Q.60, row major.
  logic signed [63:0] sm_r [NUM_M];
  logic               sm_zero_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      sm_r[0]   <= ww_r + xx_r - yy_r - zz_r;
      sm_r[1]   <= (xy_r - wz_r) <<< 1;
      sm_r[2]   <= (xz_r + wy_r) <<< 1;
      sm_r[3]   <= (xy_r + wz_r) <<< 1;
      sm_r[4]   <= ww_r - xx_r + yy_r - zz_r;
      sm_r[5]   <= (yz_r - wx_r) <<< 1;
      sm_r[6]   <= (xz_r - wy_r) <<< 1;
      sm_r[7]   <= (yz_r + wx_r) <<< 1;
      sm_r[8]   <= ww_r - xx_r - yy_r + zz_r;
      sm_zero_r <= pr_zero_r;
    end
  end

  // Output stage: round half up, saturate, identity for a zero vector.
  logic signed [OUT_WIDTH-1:0] om_r [NUM_M];
  logic                        oz_r;

  for (genvar k = 0; k < NUM_M; k++) begin : g_emit
    logic signed [63:0] rr, sat;
    assign rr  = (sm_r[k] + RND) >>> SH;
    assign sat = (rr > LIM) ? LIM : (rr < -LIM) ? -LIM : rr;
    always_ff @(posedge clk) begin
      if (adv) begin
        if (sm_zero_r) begin
          om_r[k] <= ((k % 4) == 0) ? OUT_WIDTH'(LIM) : '0;
        end else begin
          om_r[k] <= OUT_WIDTH'(sat);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oz_r <= sm_zero_r;
    end
  end

  assign out_m00         = om_r[0];
  assign out_m01         = om_r[1];
  assign out_m02         = om_r[2];
  assign out_m10         = om_r[3];
  assign out_m11         = om_r[4];
  assign out_m12         = om_r[5];
  assign out_m20         = om_r[6];
  assign out_m21         = om_r[7];
  assign out_m22         = om_r[8];
  assign out_zero_vector = oz_r;

  // A zero vector result has ones on the diagonal and zero in m01, m12 and m20.
  a_zero_identity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_vector |->
      out_m00 == OUT_WIDTH'(LIM) && out_m11 == OUT_WIDTH'(LIM) &&
      out_m22 == OUT_WIDTH'(LIM) && out_m01 == '0 && out_m12 == '0 && out_m20 == '0)
    else $error("zero vector result is not the identity");

  // Entries m00 and m12 stay within the saturation limits.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 64'(out_m00) <= LIM && 64'(out_m00) >= -LIM &&
                  64'(out_m12) <= LIM && 64'(out_m12) >= -LIM)
    else $error("matrix entry outside saturation range");

  // The input side is held exactly while a result waits.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

  // No result is shown in the cycle after reset.
  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule
